/* rtl/deq_pkg.sv */
// deq_pkg: shared codes, widths and the cell control struct of the deque
// used by deq_cell, deq_ctrl and double_ended_queue; depends on nothing
`default_nettype none

package deq_pkg;

  localparam int WORD_W = 32;
  localparam int MODE_W = 2;
  localparam int KIND_W = 2;
  localparam int DEFAULT_CAPACITY = 16;

  // operation codes on mode
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELEMENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd3;

  // the operation every cell of the chain performs
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [WORD_W-1:0]  value;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/deq_cell.sv */
// deq_cell: one slot of the deque chain, position IDX from the front
// depends on deq_pkg for the cell control struct and word width
`default_nettype none

module deq_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  wire logic                       clk_i,
  input  wire deq_pkg::cell_ctl_t         ctl_i,
  input  wire logic [CNT_W-1:0]           count_i,
  input  wire logic [deq_pkg::WORD_W-1:0] left_i,
  input  wire logic [deq_pkg::WORD_W-1:0] right_i,
  input  wire logic [deq_pkg::WORD_W-1:0] front_i,
  output logic      [deq_pkg::WORD_W-1:0] word_o,
  output logic      [deq_pkg::WORD_W-1:0] tail_o
);

  localparam logic [CNT_W-1:0] POS_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS1_C = CNT_W'(IDX + 1);

  logic [deq_pkg::WORD_W-1:0] word_q, word_d;
  logic                       is_tail;

  assign is_tail = (count_i == POS1_C);

  always_comb begin
    word_d = word_q;
    case (ctl_i.op)
      deq_pkg::CELL_HOLD: word_d = word_q;
      deq_pkg::CELL_PUSH_FRONT: begin
        word_d = (IDX == 0) ? ctl_i.value : left_i;
      end
      deq_pkg::CELL_PUSH_BACK: begin
        if (count_i == POS_C) word_d = ctl_i.value;
      end
      deq_pkg::CELL_POP_FRONT: word_d = right_i;
      // front word wraps round to the tail slot
      deq_pkg::CELL_ROTATE: word_d = is_tail ? front_i : right_i;
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign tail_o = is_tail ? word_q : '0;

endmodule

`default_nettype wire

/* rtl/deq_ctrl.sv */
// deq_ctrl: sequencer of the deque, holds the fill count and result register
// depends on deq_pkg for codes and the cell control struct
`default_nettype none

module deq_ctrl #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [deq_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [deq_pkg::WORD_W-1:0]  value_i,
  input  wire logic [deq_pkg::WORD_W-1:0]  front_word_i,
  input  wire logic [deq_pkg::WORD_W-1:0]  tail_word_i,
  output deq_pkg::cell_ctl_t               ctl_o,
  output logic      [CNT_W-1:0]            count_o,
  output logic                             strobe_o,
  output logic      [deq_pkg::KIND_W-1:0]  kind_o,
  output logic      [deq_pkg::WORD_W-1:0]  word_o,
  output logic                             last_o
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_LIST = 1'b1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [0:0]                 state_q, state_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           idx_q, idx_d;
  logic                       strobe_q, strobe_d;
  logic [deq_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [deq_pkg::WORD_W-1:0] word_q, word_d;
  logic                       last_q, last_d;
  logic [CNT_W-1:0]           next_cnt;
  logic                       list_end;

  assign list_end = ((idx_q + ONE_C) == count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    strobe_d  = 1'b0;
    kind_d    = kind_q;
    word_d    = word_q;
    last_d    = last_q;
    next_cnt  = count_q;
    ctl_o.op    = deq_pkg::CELL_HOLD;
    ctl_o.value = value_i;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (mode_i)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
              if (count_q == CAP_C) begin
                strobe_d = 1'b1;
                kind_d   = deq_pkg::KIND_FULL;
                word_d   = '0;
                last_d   = 1'b0;
              end else begin
                next_cnt = count_q + ONE_C;
                ctl_o.op = (mode_i == deq_pkg::MODE_PUSH_FRONT) ?
                           deq_pkg::CELL_PUSH_FRONT : deq_pkg::CELL_PUSH_BACK;
              end
            end
            default: begin
              strobe_d = 1'b1;
              if (count_q == '0) begin
                kind_d = deq_pkg::KIND_EMPTY;
                word_d = '0;
                last_d = 1'b1;
              end else begin
                next_cnt = count_q - ONE_C;
                kind_d   = deq_pkg::KIND_REMOVED;
                last_d   = (next_cnt == '0);
                if (mode_i == deq_pkg::MODE_POP_FRONT) begin
                  word_d   = front_word_i;
                  ctl_o.op = deq_pkg::CELL_POP_FRONT;
                end else begin
                  word_d = tail_word_i;
                end
              end
            end
          endcase
          count_d = next_cnt;
          idx_d   = '0;
          state_d = (next_cnt != '0) ? ST_LIST : ST_IDLE;
        end
      end
      ST_LIST: begin
        // one element a cycle from the front, chain rotates under it
        strobe_d = 1'b1;
        kind_d   = deq_pkg::KIND_ELEMENT;
        word_d   = front_word_i;
        last_d   = list_end;
        ctl_o.op = deq_pkg::CELL_ROTATE;
        idx_d    = idx_q + ONE_C;
        if (list_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    word_q <= word_d;
    last_q <= last_d;
  end

  assign busy     = (state_q == ST_LIST);
  assign count_o  = count_q;
  assign strobe_o = strobe_q;
  assign kind_o   = kind_q;
  assign word_o   = word_q;
  assign last_o   = last_q;

endmodule

`default_nettype wire

/* rtl/double_ended_queue.sv */
// double_ended_queue: bounded deque of words kept in a chain of shift cells
// depends on deq_pkg, deq_cell and deq_ctrl
//
//   port group        dir  transfer when          contents
//   start/mode/value  in   start && !busy         operation and word to push
//   strobe/kind/...   out  strobe_o high          one result, last_o on final
//
// an item is one operation step and then a listing of the n entries left after
// the operation (up to CAPACITY); the listing shifts the chain one cell a cycle
// results are registered and show in the cycle after the step that makes them, for one cycle each
// a new item is taken while the final result of the previous one shows
// reset clears the fill count and the sequencer; cell contents are not reset
// the receiver cannot stall, so no result ever waits
`default_nettype none

module double_ended_queue #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic        [deq_pkg::MODE_W-1:0]  mode_i,
  input  wire logic signed [deq_pkg::WORD_W-1:0]  value_i,
  output logic                                    strobe_o,
  output logic             [deq_pkg::KIND_W-1:0]  kind_o,
  output logic signed      [deq_pkg::WORD_W-1:0]  word_o,
  output logic                                    last_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  deq_pkg::cell_ctl_t         ctl;
  logic [CNT_W-1:0]           count;
  logic [deq_pkg::WORD_W-1:0] cell_word [CAPACITY];
  logic [deq_pkg::WORD_W-1:0] cell_tail [CAPACITY];
  logic [deq_pkg::WORD_W-1:0] tail_word;
  logic [deq_pkg::WORD_W-1:0] word_raw;

  deq_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .value_i      ($unsigned(value_i)),
    .front_word_i (cell_word[0]),
    .tail_word_i  (tail_word),
    .ctl_o        (ctl),
    .count_o      (count),
    .strobe_o     (strobe_o),
    .kind_o       (kind_o),
    .word_o       (word_raw),
    .last_o       (last_o)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [deq_pkg::WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_word[g];
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_w = cell_word[g];
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    deq_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .count_i (count),
      .left_i  (left_w),
      .right_i (right_w),
      .front_i (cell_word[0]),
      .word_o  (cell_word[g]),
      .tail_o  (cell_tail[g])
    );
  end

  // only the cell at the back drives a nonzero tail word
  always_comb begin
    tail_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      tail_word = tail_word | cell_tail[k];
    end
  end

  assign word_o = $signed(word_raw);

  // a result that is not the final one is always followed at once by another
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("result sequence broken before its final result");

  // while listing, every cycle yields a result
  a_busy_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> strobe_o)
    else $error("listing cycle without a result");

  // pop on an empty queue gives a single empty error
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && count == '0 &&
    (mode_i == deq_pkg::MODE_POP_FRONT || mode_i == deq_pkg::MODE_POP_BACK)
    |=> strobe_o && last_o && kind_o == deq_pkg::KIND_EMPTY && word_o == '0)
    else $error("pop on empty queue not reported");

  // fill count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

endmodule

`default_nettype wire

/* tb/deq_checker.sv */
// deq_checker: watches the operation and result channels of double_ended_queue,
// predicts every result from its own ring-buffer model of the deque and compares them
// depends on deq_pkg
`timescale 1ns / 100ps

module deq_checker #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic                               busy,
  input  logic        [deq_pkg::MODE_W-1:0]  mode_i,
  input  logic signed [deq_pkg::WORD_W-1:0]  value_i,
  input  logic                               strobe_o,
  input  logic        [deq_pkg::KIND_W-1:0]  kind_o,
  input  logic signed [deq_pkg::WORD_W-1:0]  word_o,
  input  logic                               last_o,
  output int                                 fail_count,
  output int                                 outstanding,
  output int                                 op_count,
  output int                                 result_count,
  output int                                 full_count,
  output int                                 empty_count
);
  import deq_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] word;
    logic                     last;
  } deq_result_t;

  deq_result_t              pending_results[$];
  logic signed [WORD_W-1:0] ring[CAPACITY];
  int                       head_idx = 0;
  int                       fill = 0;

  initial begin
    fail_count = 0;
    outstanding = 0;
    op_count = 0;
    result_count = 0;
    full_count = 0;
    empty_count = 0;
  end

  function automatic void queue_result(logic [KIND_W-1:0] kind, logic signed [WORD_W-1:0] word);
    deq_result_t r;
    r.kind = kind;
    r.word = word;
    r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  // applies one operation to the shadow deque and queues what it must emit
  function automatic void apply_deque_op(logic [MODE_W-1:0] op, logic signed [WORD_W-1:0] val);
    deq_result_t r;
    if (op == MODE_PUSH_FRONT || op == MODE_PUSH_BACK) begin
      if (fill >= CAPACITY) begin
        queue_result(KIND_FULL, '0);
        full_count++;
      end else if (op == MODE_PUSH_FRONT) begin
        head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
        ring[head_idx] = val;
        fill++;
      end else begin
        ring[(head_idx + fill) % CAPACITY] = val;
        fill++;
      end
    end else begin
      if (fill == 0) begin
        queue_result(KIND_EMPTY, '0);
        empty_count++;
      end else if (op == MODE_POP_FRONT) begin
        queue_result(KIND_REMOVED, ring[head_idx]);
        head_idx = (head_idx + 1) % CAPACITY;
        fill--;
      end else begin
        queue_result(KIND_REMOVED, ring[(head_idx + fill - 1) % CAPACITY]);
        fill--;
      end
    end
    for (int i = 0; i < fill; i++) queue_result(KIND_ELEMENT, ring[(head_idx + i) % CAPACITY]);
    // final result of the operation carries the last flag
    r = pending_results.pop_back();
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] checker: %s", $realtime, what);
  endfunction

  always @(posedge clk_i) begin
    deq_result_t want;
    if (rst_ni) begin
      // results are compared before a transfer in the same cycle is predicted
      if (strobe_o) begin
        result_count++;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected result kind %0d word %0d last %0b",
                                 kind_o, word_o, last_o));
        end else begin
          want = pending_results.pop_front();
          if (kind_o !== want.kind || word_o !== want.word || last_o !== want.last) begin
            note_failure($sformatf(
              "result %0d: expected kind %0d word %0d last %0b, got kind %0d word %0d last %0b",
              result_count, want.kind, want.word, want.last, kind_o, word_o, last_o));
          end
        end
      end
      if (start && !busy) begin
        apply_deque_op(mode_i, value_i);
        op_count++;
      end
      outstanding = pending_results.size();
    end
  end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for double_ended_queue; directed corner operations
// then random traffic in three sender idling phases, checked by deq_checker
// depends on deq_pkg, double_ended_queue and deq_checker
`timescale 1ns / 100ps

module tb;
  import deq_pkg::*;

  localparam int CAPACITY = DEFAULT_CAPACITY;
  localparam int QUIET_LIMIT = 1000;
  localparam int OPS_PER_PHASE = 35;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [MODE_W-1:0]        mode_i = MODE_PUSH_FRONT;
  logic signed [WORD_W-1:0] value_i = '0;
  logic                     strobe_o;
  logic [KIND_W-1:0]        kind_o;
  logic signed [WORD_W-1:0] word_o;
  logic                     last_o;

  int fail_count, outstanding, op_count, result_count, full_count, empty_count;
  int idle_pct = 0;
  int quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  double_ended_queue #(.CAPACITY(CAPACITY)) uut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .value_i,
    .strobe_o, .kind_o, .word_o, .last_o
  );

  deq_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .value_i,
    .strobe_o, .kind_o, .word_o, .last_o,
    .fail_count, .outstanding, .op_count, .result_count, .full_count, .empty_count
  );

  // watchdog: ends the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("double_ended_queue regression: fail");
        $finish;
      end
    end
  end

  task automatic issue_op(input logic [MODE_W-1:0] op, input logic signed [WORD_W-1:0] val);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= op;
    value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    logic [MODE_W-1:0]        op;
    logic signed [WORD_W-1:0] val;
    int                       push_pct;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pops, extreme words, a pop that empties the deque
    issue_op(MODE_POP_FRONT, $urandom);
    issue_op(MODE_PUSH_FRONT, 32'sh7fffffff);
    issue_op(MODE_PUSH_BACK, 32'sh80000000);
    issue_op(MODE_POP_BACK, $urandom);
    issue_op(MODE_POP_FRONT, $urandom);
    issue_op(MODE_POP_BACK, $urandom);
    // fill from both ends so the ring wraps, then push into a full deque
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 4)
        0: val = '0;
        1: val = -1;
        2: val = 32'shaaaaaaaa;
        default: val = 32'sh55555555;
      endcase
      issue_op((i % 2 == 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, val);
    end
    issue_op(MODE_PUSH_FRONT, 32'sh12345678);
    issue_op(MODE_PUSH_BACK, -32'sd5);

    // random phases; push bias moves the fill level between full and empty
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  push_pct = 50; end
        1: begin idle_pct = 86; push_pct = 72; end
        default: begin idle_pct = 28; push_pct = 30; end
      endcase
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        if ($urandom_range(99) < push_pct) op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        else op = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
        case ($urandom_range(9))
          0: val = 32'sh7fffffff;
          1: val = 32'sh80000000;
          2: val = $urandom_range(1) ? -1 : 0;
          default: val = $urandom;
        endcase
        issue_op(op, val);
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (CAPACITY + 4) @(posedge clk_i);

    $display("applied %0d deque operations, checked %0d results", op_count, result_count);
    $display("predicted %0d full errors and %0d empty errors, %0d mismatches",
             full_count, empty_count, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
tb/deq_checker.sv
tb/tb.sv
